[rtl/core/gcmb_pkg.sv]
// Shared types and constants for the GC mark bitmap engine.
// No dependencies; the core modules refer to it by scoped names, the bench files import it.
package gcmb_pkg;

    localparam int unsigned BITMAP_WORDS = 4096;
    localparam int unsigned DW_SHIFT     = 3;
    localparam int unsigned WORD_SHIFT   = 5;
    localparam int unsigned BIT_MASK     = 31;

    localparam int unsigned WORD_AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned BIT_AW  = WORD_AW + WORD_SHIFT;
    localparam int unsigned ROW_LSB = DW_SHIFT + WORD_SHIFT;

    localparam logic [1:0] FUNC_MARK   = 2'd0;
    localparam logic [1:0] FUNC_TEST   = 2'd1;
    localparam logic [1:0] FUNC_RANGE  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [31:0] range_limit;
    } req_t;

    typedef struct packed {
        logic was_marked;
        logic error;
    } res_t;

    typedef struct packed {
        logic              covered;
        logic [BIT_AW-1:0] bit_idx;
    } loc_t;

endpackage

[rtl/core/gcmb_locate.sv]
// Address locate unit: byte address to bitmap bit index, with coverage check.
// Depends on gcmb_pkg.
module gcmb_locate
(
    input  logic [31:0]    addr,
    input  logic [31:0]    base,
    output gcmb_pkg::loc_t loc
);

    localparam int unsigned ROW_W = 32 - gcmb_pkg::ROW_LSB;

    logic [32:0]      diff;
    logic [ROW_W-1:0] row;

    assign diff = {1'b0, addr} - {1'b0, base};
    assign row  = diff[31:gcmb_pkg::ROW_LSB];

    assign loc.covered = !diff[32]
                       && ({{(32 - ROW_W){1'b0}}, row} < 32'(gcmb_pkg::BITMAP_WORDS));
    assign loc.bit_idx = diff[gcmb_pkg::BIT_AW + gcmb_pkg::DW_SHIFT - 1:gcmb_pkg::DW_SHIFT];

endmodule

[rtl/core/gcmb_ctrl.sv]
// Sequencer and bitmap store: clearing pass, locate steps, read-modify-write loop.
// Depends on gcmb_pkg and gcmb_locate.
module gcmb_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  gcmb_pkg::req_t req,
    input  logic [31:0]    heap_base,
    output logic           res_valid,
    input  logic           res_ack,
    output gcmb_pkg::res_t res
);

    localparam int unsigned WAW = gcmb_pkg::WORD_AW;
    localparam int unsigned BAW = gcmb_pkg::BIT_AW;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_LOC_A = 7'b0000100,
        ST_LOC_B = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [WAW-1:0]  clr_reg, clr_next;
    logic [1:0]      func_reg, func_next;
    logic [31:0]     addr_reg, addr_next;
    logic [31:0]     lim_m1_reg, lim_m1_next;
    logic            empty_reg, empty_next;
    logic [BAW-1:0]  lo_reg, lo_next;
    logic [BAW-1:0]  hi_reg, hi_next;
    logic [WAW-1:0]  cur_reg, cur_next;
    logic            was_reg, was_next;
    logic            err_reg, err_next;
    logic [31:0]     rdata_reg;

    logic [31:0]     mem [gcmb_pkg::BITMAP_WORDS];

    gcmb_pkg::loc_t  loc;
    logic [31:0]     loc_addr;
    logic [WAW-1:0]  lo_word, hi_word;
    logic [4:0]      lo_bit, hi_bit;
    logic [31:0]     mask;
    logic            mem_we;
    logic [WAW-1:0]  mem_waddr;
    logic [31:0]     mem_wdata;

    assign loc_addr = (state_reg == ST_LOC_B) ? lim_m1_reg : addr_reg;

    gcmb_locate u_locate
    (
        .addr (loc_addr),
        .base (heap_base),
        .loc  (loc)
    );

    assign lo_word = lo_reg[BAW-1:gcmb_pkg::WORD_SHIFT];
    assign hi_word = hi_reg[BAW-1:gcmb_pkg::WORD_SHIFT];
    assign lo_bit  = lo_reg[4:0];
    assign hi_bit  = hi_reg[4:0];

    always_comb
    begin
        if (func_reg == gcmb_pkg::FUNC_RANGE)
        begin
            mask = '1;
            if (cur_reg == lo_word)
            begin
                mask = mask & (32'hFFFF_FFFF << lo_bit);
            end
            if (cur_reg == hi_word)
            begin
                mask = mask & (32'hFFFF_FFFF >> (5'(gcmb_pkg::BIT_MASK) - hi_bit));
            end
        end
        else
        begin
            mask = 32'd1 << lo_bit;
        end
    end

    assign mem_we    = (state_reg == ST_CLEAR)
                     || ((state_reg == ST_WRITE) && (func_reg != gcmb_pkg::FUNC_TEST));
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : cur_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 32'd0 : (rdata_reg | mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= mem[cur_reg];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        lim_m1_next = lim_m1_reg;
        empty_next  = empty_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        cur_next    = cur_reg;
        was_next    = was_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WAW'(gcmb_pkg::BITMAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next   = req.func;
                    addr_next   = req.address;
                    lim_m1_next = req.range_limit - 32'd1;
                    empty_next  = (req.range_limit <= req.address);
                    state_next  = ST_LOC_A;
                end
            end
            ST_LOC_A:
            begin
                lo_next  = loc.bit_idx;
                cur_next = loc.bit_idx[BAW-1:gcmb_pkg::WORD_SHIFT];
                if (!loc.covered || (func_reg == gcmb_pkg::FUNC_UNUSED))
                begin
                    was_next   = 1'b0;
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (func_reg == gcmb_pkg::FUNC_RANGE)
                begin
                    state_next = ST_LOC_B;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_LOC_B:
            begin
                hi_next = loc.bit_idx;
                if (!loc.covered || empty_reg)
                begin
                    was_next   = 1'b0;
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                err_next = 1'b0;
                if (func_reg == gcmb_pkg::FUNC_RANGE)
                begin
                    was_next = 1'b0;
                    if (cur_reg == hi_word)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    was_next   = rdata_reg[lo_bit];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        addr_reg   <= addr_next;
        lim_m1_reg <= lim_m1_next;
        empty_reg  <= empty_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        cur_reg    <= cur_next;
        was_reg    <= was_next;
        err_reg    <= err_next;
    end

    assign req_ready      = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_DONE);
    assign res.was_marked = was_reg;
    assign res.error      = err_reg;

endmodule

[rtl/core/gc_mark_bitmap_engine.sv]
// Top level of the GC mark bitmap engine: streams, base register, result register.
// Depends on gcmb_pkg and gcmb_ctrl.
//
//   channel   | direction | transfer carries
//   s_axis    | in        | func, address, range_limit
//   m_axis    | out       | was_marked, error
//   cfg       | in        | heap_base
//
// After reset a clearing pass zeroes the bitmap, one word a cycle, no input taken.
// Mark or test: locate, read, write, then result; an error shows from a locate step.
// Mark range: two locate steps, then each word touched costs a read and a write on the
// single bitmap port. One item is in work at a time; a waiting result sits in the
// output register while the next item runs.
module gc_mark_bitmap_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // address[31:0], range_limit[63:32]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // was_marked[0], zero fill[7:1]
    output logic        m_axis_tuser,   // error[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data        // heap_base[31:0]
);

    logic [31:0]    heap_base_reg, heap_base_next;
    logic           out_valid_reg, out_valid_next;
    gcmb_pkg::res_t out_res_reg, out_res_next;

    gcmb_pkg::req_t req;
    gcmb_pkg::res_t res;
    logic           res_valid;
    logic           res_take;

    assign req.func        = s_axis_tuser;
    assign req.address     = s_axis_tdata[31:0];
    assign req.range_limit = s_axis_tdata[63:32];

    gcmb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .heap_base (heap_base_reg),
        .res_valid (res_valid),
        .res_ack   (res_take),
        .res       (res)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        heap_base_next = cfg_valid ? cfg_data : heap_base_reg;
        out_res_next   = res_take ? res : out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.was_marked};
    assign m_axis_tuser  = out_res_reg.error;

endmodule

[rtl/core/gcmb_checker.sv]
// Port-level checks for the GC mark bitmap engine, bound to the top level.
// Depends on gc_mark_bitmap_engine port names only.
module gcmb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on two consecutive cycles");

    a_error_clears_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
        else $error("refused request reports a set mark");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("result fill bits not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind gc_mark_bitmap_engine gcmb_checker u_gcmb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[bench/gcmb_result_checker.sv]
// Result checker for the GC mark bitmap engine: mirrors the bitmap and the base register,
// predicts each result from the input transfers and compares it with the output transfers.
// Depends on gcmb_pkg only.
`timescale 1ns / 100ps

module gcmb_result_checker
    import gcmb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // address[31:0], range_limit[63:32]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // was_marked[0], zero fill[7:1]
    input  logic        m_axis_tuser,   // error[0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,       // heap_base[31:0]
    output int          mismatches,
    output int          outstanding,
    output int          items_seen,
    output int          hits,
    output int          refusals
);

    logic [31:0] shadow_bits [BITMAP_WORDS];
    logic [31:0] base_addr;
    res_t        pending_results [$];
    res_t        due;
    res_t        fresh;
    req_t        request;

    function automatic logic covers(input logic [31:0] addr, output logic [31:0] dw);
        logic [31:0] offset;
        offset = addr - base_addr;
        dw = offset >> DW_SHIFT;
        return (addr >= base_addr) && ((dw >> WORD_SHIFT) < BITMAP_WORDS);
    endfunction

    function automatic res_t apply_request(input req_t rq);
        res_t        r;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mask;
        logic        lo_ok;
        logic        hi_ok;
        int unsigned w;
        int unsigned first_bit;
        int unsigned last_bit;
        r = '0;
        case (rq.func)
            FUNC_MARK, FUNC_TEST:
            begin
                if (!covers(rq.address, lo))
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    r.was_marked = shadow_bits[lo >> WORD_SHIFT][lo[4:0]];
                    if (rq.func == FUNC_MARK)
                    begin
                        shadow_bits[lo >> WORD_SHIFT][lo[4:0]] = 1'b1;
                    end
                end
            end
            FUNC_RANGE:
            begin
                lo_ok = covers(rq.address, lo);
                hi_ok = covers(rq.range_limit - 32'd1, hi);
                if (rq.range_limit <= rq.address || !lo_ok || !hi_ok)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    for (w = lo >> WORD_SHIFT; w <= (hi >> WORD_SHIFT); w++)
                    begin
                        first_bit = (w == (lo >> WORD_SHIFT)) ? lo[4:0] : 0;
                        last_bit  = (w == (hi >> WORD_SHIFT)) ? hi[4:0] : BIT_MASK;
                        mask = (32'hFFFF_FFFF << first_bit)
                             & (32'hFFFF_FFFF >> (BIT_MASK - last_bit));
                        shadow_bits[w] = shadow_bits[w] | mask;
                    end
                end
            end
            default:
            begin
                r.error = 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BITMAP_WORDS; i++)
            begin
                shadow_bits[i] = '0;
            end
            base_addr = '0;
            pending_results.delete();
            mismatches = 0;
            items_seen = 0;
            hits       = 0;
            refusals   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result transfer, was_marked=%0b error=%0b",
                             $time, m_axis_tdata[0], m_axis_tuser);
                end
                else
                begin
                    due = pending_results.pop_front();
                    if (due.was_marked !== m_axis_tdata[0])
                    begin
                        mismatches++;
                        $display("%0t: was_marked expected %0b, got %0b",
                                 $time, due.was_marked, m_axis_tdata[0]);
                    end
                    if (due.error !== m_axis_tuser)
                    begin
                        mismatches++;
                        $display("%0t: error expected %0b, got %0b",
                                 $time, due.error, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                request.func        = s_axis_tuser;
                request.address     = s_axis_tdata[31:0];
                request.range_limit = s_axis_tdata[63:32];
                fresh = apply_request(request);
                pending_results.push_back(fresh);
                items_seen++;
                hits     += fresh.was_marked;
                refusals += fresh.error;
            end
            if (cfg_valid && cfg_ready)
            begin
                base_addr = cfg_data;
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

[bench/tb.sv]
// Top of the mark bitmap bench: clock, reset, stimulus for the request, result and base
// register channels, watchdog and verdict. Depends on gcmb_pkg, gc_mark_bitmap_engine
// and gcmb_result_checker.
`timescale 1ns / 100ps

module tb;

    import gcmb_pkg::*;

    localparam int unsigned COVER_BYTES   = BITMAP_WORDS << (WORD_SHIFT + DW_SHIFT);
    localparam int          QUIET_LIMIT   = 40000;
    localparam int          PHASE_ITEMS   = 120;
    localparam int          SETTLE_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // address[31:0], range_limit[63:32]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // was_marked[0], zero fill[7:1]
    logic        m_axis_tuser;   // error[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;       // heap_base[31:0]

    int          mismatches;
    int          outstanding;
    int          items_seen;
    int          hits;
    int          refusals;

    logic        calm;
    int          stall_left;
    int          quiet;
    int          n_settings;
    logic [31:0] heap_base;
    logic [31:0] hot_base;

    gc_mark_bitmap_engine i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    gcmb_result_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .items_seen    (items_seen),
        .hits          (hits),
        .refusals      (refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stall the result side in bursts of random length while not calm
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input logic [31:0] lim);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {lim, addr};
        do @(posedge clk); while (!s_axis_tready);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // hold the request side until every result has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        heap_base = value;
        hot_base  = value + ($urandom_range(0, 255) << 12);
        n_settings++;
    endtask

    task automatic random_item;
        int          r;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] lim;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = FUNC_MARK;
        else if (r < 70)
            op = FUNC_TEST;
        else if (r < 95)
            op = FUNC_RANGE;
        else
            op = FUNC_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 55)
            addr = hot_base + $urandom_range(0, 4095);
        else if (r < 75)
            addr = heap_base + $urandom_range(0, COVER_BYTES - 1);
        else if (r < 82)
            addr = heap_base - $urandom_range(1, 64);
        else if (r < 88)
            addr = heap_base + COVER_BYTES - 1 - $urandom_range(0, 63);
        else if (r < 93)
            addr = heap_base + COVER_BYTES + $urandom_range(0, 63);
        else
            addr = $urandom;
        r = $urandom_range(0, 99);
        if (op != FUNC_RANGE || r >= 92)
            lim = $urandom;
        else if (r < 50)
            lim = addr + $urandom_range(1, 80);
        else if (r < 75)
            lim = addr + $urandom_range(1, 2000);
        else if (r < 85)
            lim = addr + $urandom_range(1, 65536);
        else
            lim = addr - $urandom_range(0, 16);
        send_item(op, addr, lim);
        if ($urandom_range(0, 149) == 0)
        begin
            drain;
        end
    endtask

    initial
    begin
        logic [31:0] next_base;
        int          n_items;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_MARK;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        calm          = 1'b0;
        stall_left    = 0;
        quiet         = 0;
        n_settings    = 0;
        heap_base     = '0;
        hot_base      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_base(32'h0000_1000);
        send_item(FUNC_MARK,   32'h0000_1000, 32'h0);
        send_item(FUNC_MARK,   32'h0000_1007, 32'hFFFF_FFFF);
        send_item(FUNC_TEST,   32'h0000_1008, 32'h0);
        send_item(FUNC_TEST,   32'h0000_1000, 32'h0);
        send_item(FUNC_MARK,   32'h0000_0FFF, 32'h0);
        send_item(FUNC_TEST,   32'h0000_0000, 32'h0);
        send_item(FUNC_MARK,   32'h0000_1000 + COVER_BYTES - 1, 32'h0);
        send_item(FUNC_TEST,   32'h0000_1000 + COVER_BYTES, 32'h0);
        send_item(FUNC_TEST,   32'hFFFF_FFFF, 32'h0);
        send_item(FUNC_UNUSED, 32'h0000_1000, 32'h0000_2000);
        send_item(FUNC_RANGE,  32'h0000_1100, 32'h0000_1100);
        send_item(FUNC_RANGE,  32'h0000_1100, 32'h0000_10FF);
        send_item(FUNC_RANGE,  32'h0000_1000, 32'h0);
        send_item(FUNC_RANGE,  32'h0000_1000, 32'hFFFF_FFFF);
        send_item(FUNC_RANGE,  32'h0000_1048, 32'h0000_1051);
        send_item(FUNC_TEST,   32'h0000_1040, 32'h0);
        send_item(FUNC_TEST,   32'h0000_1050, 32'h0);
        send_item(FUNC_TEST,   32'h0000_1058, 32'h0);
        send_item(FUNC_RANGE,  32'h0000_10F8, 32'h0000_1108);
        send_item(FUNC_TEST,   32'h0000_10F0, 32'h0);
        send_item(FUNC_TEST,   32'h0000_1100, 32'h0);
        send_item(FUNC_TEST,   32'h0000_1108, 32'h0);
        send_item(FUNC_RANGE,  32'h0000_1000 + COVER_BYTES - 256,
                  32'h0000_1000 + COVER_BYTES + 1);
        send_item(FUNC_TEST,   32'h0000_1000 + COVER_BYTES - 256, 32'h0);
        send_item(FUNC_RANGE,  32'h0000_0FF8, 32'h0000_1010);
        send_item(FUNC_RANGE,  32'h0000_1200, 32'h0000_1400);
        send_item(FUNC_MARK,   32'h0000_13F8, 32'h0);
        drain;

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       next_base = 32'h0000_0000;
                1:       next_base = 32'h0012_3457;
                2:       next_base = 32'hFFF0_0000;
                3:       next_base = 32'hFFFF_FFFF;
                4:       next_base = 32'h7FFF_FFF8;
                default: next_base = $urandom;
            endcase
            write_base(next_base);
            n_items = (p == 3) ? 30 : PHASE_ITEMS;
            repeat (n_items) random_item;
            drain;
        end

        // finish without idling, filling the whole bitmap at the end
        calm <= 1'b1;
        write_base(32'h0000_0000);
        repeat (60) random_item;
        send_item(FUNC_RANGE, heap_base, heap_base + COVER_BYTES);
        send_item(FUNC_TEST,  heap_base, 32'h0);
        send_item(FUNC_TEST,  heap_base + COVER_BYTES / 2, 32'h0);
        send_item(FUNC_MARK,  heap_base + COVER_BYTES - 1, 32'h0);
        drain;

        $display("tb: %0d requests under %0d base settings: %0d hit a set bit, %0d refused",
                 items_seen, n_settings, hits, refusals);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
